// ===== hw/rtl/qlt_pkg.sv =====
// ----------------------------------------------------------------------------
// qlt_pkg
// Shared types and constants of the quoted line tokenizer.
// ----------------------------------------------------------------------------
package qlt_pkg;

  localparam int unsigned MAX_TOKENS = 16;
  localparam int unsigned MAX_LINE   = 256;
  localparam int unsigned LEN_W      = $clog2(MAX_LINE);

  localparam int unsigned CODE_W = 16;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned POS_W  = 9;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Character codes
  localparam logic [CODE_W-1:0] CH_NUL    = 16'h0000;
  localparam logic [CODE_W-1:0] CH_TAB    = 16'h0009;
  localparam logic [CODE_W-1:0] CH_LF     = 16'h000A;
  localparam logic [CODE_W-1:0] CH_CR     = 16'h000D;
  localparam logic [CODE_W-1:0] CH_SPACE  = 16'h0020;
  localparam logic [CODE_W-1:0] CH_DQUOTE = 16'h0022;
  localparam logic [CODE_W-1:0] CH_HASH   = 16'h0023;
  localparam logic [CODE_W-1:0] CH_SQUOTE = 16'h0027;
  localparam logic [CODE_W-1:0] CH_DASH   = 16'h002D;
  localparam logic [CODE_W-1:0] CH_SEMI   = 16'h003B;
  localparam logic [CODE_W-1:0] CH_BSLASH = 16'h005C;

  typedef enum logic [1:0] {
    EV_TOKEN_CHAR   = 2'd0,
    EV_TOKEN_END    = 2'd1,
    EV_COMMENT_CHAR = 2'd2,
    EV_LINE_END     = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_MANY  = 2'd1,
    ST_BACKSLASH = 2'd2
  } status_e;

  typedef enum logic {
    KIND_CHAR     = 1'b0,
    KIND_LINE_END = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]        event_res;
    logic [IDX_W-1:0]  token_index;
    logic [POS_W-1:0]  position;
    logic [CODE_W-1:0] out_code;
    logic [1:0]        status;
    logic              last;
  } res_t;

  // Results of one step: count (0..2) and up to two items in order
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

// ===== hw/rtl/qlt_in_if.sv =====
// ----------------------------------------------------------------------------
// qlt_in_if
// Input channel: one line character or an end-of-line mark per item.
// ----------------------------------------------------------------------------
interface qlt_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [qlt_pkg::CODE_W-1:0]  code;

  modport source (output valid, output kind, output code, input ready);
  modport sink   (input valid, input kind, input code, output ready);
endinterface

// ===== hw/rtl/qlt_out_if.sv =====
// ----------------------------------------------------------------------------
// qlt_out_if
// Result channel: token, comment and line-end events.
// ----------------------------------------------------------------------------
interface qlt_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  event_res;
  logic [qlt_pkg::IDX_W-1:0]   token_index;
  logic [qlt_pkg::POS_W-1:0]   position;
  logic [qlt_pkg::CODE_W-1:0]  out_code;
  logic [1:0]                  status;
  logic                        last;

  modport source (output valid, output event_res, output token_index, output position,
                  output out_code, output status, output last, input ready);
  modport sink   (input valid, input event_res, input token_index, input position,
                  input out_code, input status, input last, output ready);
endinterface

// ===== hw/rtl/qlt_step.sv =====
// ----------------------------------------------------------------------------
// qlt_step
// Tokenizer state and the per-item decision logic. Produces up to two result
// items for the item at its input and updates state when that item fires.
// ----------------------------------------------------------------------------
module qlt_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic                        kind_i,
  input  logic [qlt_pkg::CODE_W-1:0]  code_i,
  output qlt_pkg::step_t              step_o
);

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_SQUOTE  = 3'd1,
    MODE_DQUOTE  = 3'd2,
    MODE_BARE    = 3'd3,
    MODE_COMMENT = 3'd4,
    MODE_ERROR   = 3'd5
  } mode_e;

  mode_e                       mode_q, mode_d;
  logic                        esc_q, esc_d;
  logic [qlt_pkg::IDX_W-1:0]   tcount_q, tcount_d;
  logic [qlt_pkg::POS_W-1:0]   offset_q, offset_d;
  logic                        strip_q, strip_d;
  logic [1:0]                  lstat_q, lstat_d;
  logic [qlt_pkg::LEN_W-1:0]   llen_q, llen_d;
  logic                        lcut_q, lcut_d;

  function automatic qlt_pkg::res_t mk_res(input logic [1:0] ev,
                                           input logic [qlt_pkg::IDX_W-1:0] idx,
                                           input logic [qlt_pkg::POS_W-1:0] pos,
                                           input logic [qlt_pkg::CODE_W-1:0] ch,
                                           input logic [1:0] st);
    qlt_pkg::res_t r;
    r.event_res   = ev;
    r.token_index = idx;
    r.position    = pos;
    r.out_code    = ch;
    r.status      = st;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic logic [qlt_pkg::POS_W-1:0] sat_inc(input logic [qlt_pkg::POS_W-1:0] v);
    return (v == qlt_pkg::POS_MAX) ? v : v + 1'b1;
  endfunction

  always_comb begin
    mode_e                       md;
    logic                        esc;
    logic [qlt_pkg::IDX_W-1:0]   tc;
    logic [qlt_pkg::POS_W-1:0]   off;
    logic                        strip;
    logic [1:0]                  lst;
    logic                        esc_path;
    logic                        do_char;
    logic                        do_end;
    logic                        do_comment;
    logic                        is_closer;
    logic                        open_end;
    qlt_pkg::step_t              s;

    md         = mode_q;
    esc        = esc_q;
    tc         = tcount_q;
    off        = offset_q;
    strip      = strip_q;
    lst        = lstat_q;
    esc_path   = 1'b0;
    do_char    = 1'b0;
    do_end     = 1'b0;
    do_comment = 1'b0;
    is_closer  = 1'b0;
    open_end   = 1'b0;
    s          = '0;
    llen_d     = llen_q;
    lcut_d     = lcut_q;

    if (kind_i == qlt_pkg::KIND_LINE_END) begin
      // Close an open token, unless a backslash is left dangling
      if (mode_q == MODE_SQUOTE) begin
        open_end = 1'b1;
      end else if (mode_q == MODE_DQUOTE || mode_q == MODE_BARE) begin
        if (esc_q) begin
          lst = qlt_pkg::ST_BACKSLASH;
        end else begin
          open_end = 1'b1;
        end
      end
      if (open_end) begin
        s.n  = 2'd2;
        s.r0 = mk_res(qlt_pkg::EV_TOKEN_END, tcount_q - 1'b1, offset_q, '0, qlt_pkg::ST_OK);
        s.r1 = mk_res(qlt_pkg::EV_LINE_END, tcount_q, '0, '0, lst);
      end else begin
        s.n  = 2'd1;
        s.r0 = mk_res(qlt_pkg::EV_LINE_END, tcount_q, '0, '0, lst);
      end
      // Return to reset state
      md     = MODE_BETWEEN;
      esc    = 1'b0;
      tc     = '0;
      off    = '0;
      strip  = 1'b1;
      lst    = qlt_pkg::ST_OK;
      llen_d = '0;
      lcut_d = 1'b0;
    end else if (lcut_q || llen_q >= qlt_pkg::LEN_W'(qlt_pkg::MAX_LINE - 1)) begin
      // Drop characters past the line cut or the line length limit
    end else if (code_i == qlt_pkg::CH_NUL || code_i == qlt_pkg::CH_LF ||
                 code_i == qlt_pkg::CH_CR) begin
      lcut_d = 1'b1;
    end else begin
      llen_d = llen_q + 1'b1;
      case (mode_q)
        MODE_BETWEEN: begin
          if (code_i != qlt_pkg::CH_SPACE && code_i != qlt_pkg::CH_TAB) begin
            if (tc >= qlt_pkg::IDX_W'(qlt_pkg::MAX_TOKENS)) begin
              md  = MODE_ERROR;
              lst = qlt_pkg::ST_TOO_MANY;
              esc = 1'b0;
            end else begin
              off = '0;
              esc = 1'b0;
              if (code_i == qlt_pkg::CH_SEMI || code_i == qlt_pkg::CH_HASH) begin
                md         = MODE_COMMENT;
                do_comment = 1'b1;
              end else begin
                tc = tc + 1'b1;
                if (code_i == qlt_pkg::CH_SQUOTE) begin
                  md = MODE_SQUOTE;
                end else if (code_i == qlt_pkg::CH_DQUOTE) begin
                  md = MODE_DQUOTE;
                end else begin
                  md       = MODE_BARE;
                  esc_path = 1'b1;
                end
              end
            end
          end
        end
        MODE_SQUOTE: begin
          if (code_i == qlt_pkg::CH_SQUOTE) begin
            do_end = 1'b1;
          end else begin
            do_char = 1'b1;
          end
        end
        MODE_DQUOTE:  esc_path   = 1'b1;
        MODE_BARE:    esc_path   = 1'b1;
        MODE_COMMENT: do_comment = 1'b1;
        default: ;
      endcase

      if (esc_path) begin
        is_closer = (md == MODE_DQUOTE) ? (code_i == qlt_pkg::CH_DQUOTE)
                  : (code_i == qlt_pkg::CH_SPACE || code_i == qlt_pkg::CH_TAB);
        if (esc) begin
          if (code_i == qlt_pkg::CH_DQUOTE || code_i == qlt_pkg::CH_SPACE ||
              code_i == qlt_pkg::CH_BSLASH) begin
            esc     = 1'b0;
            do_char = 1'b1;
          end else begin
            md  = MODE_ERROR;
            lst = qlt_pkg::ST_BACKSLASH;
            esc = 1'b0;
          end
        end else if (code_i == qlt_pkg::CH_BSLASH) begin
          esc = 1'b1;
        end else if (is_closer) begin
          do_end = 1'b1;
        end else begin
          do_char = 1'b1;
        end
      end

      if (do_char) begin
        // Drop leading dashes of the first token
        if (!(tc == qlt_pkg::IDX_W'(1) && strip && code_i == qlt_pkg::CH_DASH)) begin
          s.n   = 2'd1;
          s.r0  = mk_res(qlt_pkg::EV_TOKEN_CHAR, tc - 1'b1, off, code_i, qlt_pkg::ST_OK);
          strip = 1'b0;
          off   = sat_inc(off);
        end
      end
      if (do_end) begin
        s.n  = 2'd1;
        s.r0 = mk_res(qlt_pkg::EV_TOKEN_END, tc - 1'b1, off, '0, qlt_pkg::ST_OK);
        if (tc == qlt_pkg::IDX_W'(1)) begin
          strip = 1'b0;
        end
        off = '0;
        esc = 1'b0;
        md  = MODE_BETWEEN;
      end
      if (do_comment) begin
        s.n  = 2'd1;
        s.r0 = mk_res(qlt_pkg::EV_COMMENT_CHAR, tc, off, code_i, qlt_pkg::ST_OK);
        off  = sat_inc(off);
      end
    end

    if (s.n == 2'd1) begin
      s.r0.last = 1'b1;
    end
    if (s.n == 2'd2) begin
      s.r1.last = 1'b1;
    end

    step_o   = s;
    mode_d   = md;
    esc_d    = esc;
    tcount_d = tc;
    offset_d = off;
    strip_d  = strip;
    lstat_d  = lst;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BETWEEN;
      esc_q    <= 1'b0;
      tcount_q <= '0;
      offset_q <= '0;
      strip_q  <= 1'b1;
      lstat_q  <= qlt_pkg::ST_OK;
      llen_q   <= '0;
      lcut_q   <= 1'b0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      esc_q    <= esc_d;
      tcount_q <= tcount_d;
      offset_q <= offset_d;
      strip_q  <= strip_d;
      lstat_q  <= lstat_d;
      llen_q   <= llen_d;
      lcut_q   <= lcut_d;
    end
  end

endmodule

// ===== hw/rtl/qlt_res_fifo.sv =====
// ----------------------------------------------------------------------------
// qlt_res_fifo
// Two-entry result buffer. Takes up to two items per cycle, gives one when the reader is ready.
// ----------------------------------------------------------------------------
module qlt_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [1:0]     push_n_i,
  input  qlt_pkg::res_t  push0_i,
  input  qlt_pkg::res_t  push1_i,
  input  logic           pop_ready_i,
  output logic           head_valid_o,
  output qlt_pkg::res_t  head_o,
  output logic [1:0]     free_o
);

  qlt_pkg::res_t  ent_q [2];
  qlt_pkg::res_t  ent_d [2];
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;

  assign pop          = (cnt_q != 2'd0) && pop_ready_i;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = ent_q[0];
  // Slots free this cycle, counting the one that drains
  assign free_o       = 2'd2 - cnt_q + {1'b0, pop};

  always_comb begin
    logic [1:0] c;
    ent_d = ent_q;
    c     = cnt_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
      c        = c - 1'b1;
    end
    if (push_i && push_n_i != 2'd0) begin
      ent_d[c[0]] = push0_i;
      if (push_n_i == 2'd2) begin
        ent_d[1] = push1_i;
      end
      c = c + push_n_i;
    end
    cnt_d = c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ===== hw/rtl/quoted_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quoted_line_tokenizer
// Shell-style tokenizer: splits a character stream into tokens, quotes,
// escapes and comments, and reports one line-end item per line.
// ----------------------------------------------------------------------------
//   channel | dir | fields
//   in_i    | in  | kind (1), code (16)
//   out_o   | out | event_res (2), token_index (5), position (9),
//           |     | out_code (16), status (2), last (1)
//
// One item per cycle while the result buffer has room: an accepted item sits
// in the input register, the step logic decides its results combinationally
// and pushes them into a two-entry result buffer. A line end that closes an
// open token gives two results in turn; all other items give at most one.
// Reset clears the tokenizer state and both buffers; no clearing pass.
// The input stalls only while the result buffer lacks room for the next item.
// ----------------------------------------------------------------------------
module quoted_line_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  qlt_in_if.sink     in_i,
  qlt_out_if.source  out_o
);

  logic                        s1_valid_q;
  logic                        s1_kind_q;
  logic [qlt_pkg::CODE_W-1:0]  s1_code_q;
  logic                        s1_fire;
  logic                        in_fire;
  logic [1:0]                  free;
  logic                        head_valid;
  qlt_pkg::res_t               head;
  qlt_pkg::step_t              step;

  assign s1_fire  = s1_valid_q && (step.n <= free);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= in_i.kind;
      s1_code_q <= in_i.code;
    end
  end

  qlt_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .kind_i (s1_kind_q),
    .code_i (s1_code_q),
    .step_o (step)
  );

  qlt_res_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (s1_fire),
    .push_n_i     (step.n),
    .push0_i      (step.r0),
    .push1_i      (step.r1),
    .pop_ready_i  (out_o.ready),
    .head_valid_o (head_valid),
    .head_o       (head),
    .free_o       (free)
  );

  assign out_o.valid       = head_valid;
  assign out_o.event_res   = head.event_res;
  assign out_o.token_index = head.token_index;
  assign out_o.position    = head.position;
  assign out_o.out_code    = head.out_code;
  assign out_o.status      = head.status;
  assign out_o.last        = head.last;

  // A character never yields more than one result
  a_char_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (s1_kind_q == qlt_pkg::KIND_CHAR) |-> step.n <= 2'd1)
    else $error("character item produced two results");

  // Two results only as token end followed by line end
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (step.n == 2'd2) |->
      (step.r0.event_res == qlt_pkg::EV_TOKEN_END) &&
      (step.r1.event_res == qlt_pkg::EV_LINE_END) && !step.r0.last && step.r1.last)
    else $error("bad result pair");

  // A line end always closes the item's results
  a_line_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.event_res == qlt_pkg::EV_LINE_END) |-> out_o.last)
    else $error("line end not marked last");

  // Buffer never overfills
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free <= 2'd2)
    else $error("result buffer overflow");

endmodule

// ===== tb/qlt_token_checker.sv =====
// ----------------------------------------------------------------------------
// qlt_token_checker
// Watches both channels of the quoted line tokenizer. Every accepted input
// item runs through a cycle-free model of the tokenizer, and the events it
// should cause are queued. Every accepted result is compared field by field
// with the oldest queued event.
// ----------------------------------------------------------------------------
module qlt_token_checker (
  input  logic clk_i,
  input  logic rst_ni,
  qlt_in_if    in_i,
  qlt_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    SCAN_BETWEEN,
    SCAN_SQUOTE,
    SCAN_DQUOTE,
    SCAN_BARE,
    SCAN_COMMENT,
    SCAN_ERROR
  } scan_mode_e;

  scan_mode_e                  scan_mode;
  bit                          esc_pending;
  logic [qlt_pkg::IDX_W-1:0]   tok_cnt;
  logic [qlt_pkg::POS_W-1:0]   offset;
  bit                          strip_dash;
  qlt_pkg::status_e            line_st;
  logic [qlt_pkg::LEN_W-1:0]   line_len;
  bit                          line_cut;

  qlt_pkg::res_t expected_q[$];
  int            fail_cnt = 0;

  function automatic void reset_scan();
    scan_mode   = SCAN_BETWEEN;
    esc_pending = 1'b0;
    tok_cnt     = '0;
    offset      = '0;
    strip_dash  = 1'b1;
    line_st     = qlt_pkg::ST_OK;
    line_len    = '0;
    line_cut    = 1'b0;
  endfunction

  function automatic void add_event(qlt_pkg::event_e ev,
                                    logic [qlt_pkg::IDX_W-1:0] idx,
                                    logic [qlt_pkg::POS_W-1:0] pos,
                                    logic [qlt_pkg::CODE_W-1:0] ch,
                                    qlt_pkg::status_e st);
    qlt_pkg::res_t r;
    r.event_res   = ev;
    r.token_index = idx;
    r.position    = pos;
    r.out_code    = ch;
    r.status      = st;
    r.last        = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void bump_offset();
    if (offset != qlt_pkg::POS_MAX) offset++;
  endfunction

  function automatic void token_char(logic [qlt_pkg::CODE_W-1:0] c);
    // drop leading dashes of the first token
    if (tok_cnt == 1 && strip_dash && c == qlt_pkg::CH_DASH) return;
    strip_dash = 1'b0;
    add_event(qlt_pkg::EV_TOKEN_CHAR, tok_cnt - 1'b1, offset, c, qlt_pkg::ST_OK);
    bump_offset();
  endfunction

  function automatic void close_token();
    add_event(qlt_pkg::EV_TOKEN_END, tok_cnt - 1'b1, offset, '0, qlt_pkg::ST_OK);
    if (tok_cnt == 1) strip_dash = 1'b0;
    offset      = '0;
    esc_pending = 1'b0;
    scan_mode   = SCAN_BETWEEN;
  endfunction

  function automatic void raise_error(qlt_pkg::status_e st);
    line_st     = st;
    scan_mode   = SCAN_ERROR;
    esc_pending = 1'b0;
  endfunction

  // Character inside a double-quoted or bare token, where backslash escapes
  function automatic void escapable_char(logic [qlt_pkg::CODE_W-1:0] c,
                                         logic [qlt_pkg::CODE_W-1:0] stop_a,
                                         logic [qlt_pkg::CODE_W-1:0] stop_b);
    if (esc_pending) begin
      if (c == qlt_pkg::CH_DQUOTE || c == qlt_pkg::CH_SPACE || c == qlt_pkg::CH_BSLASH) begin
        esc_pending = 1'b0;
        token_char(c);
      end else begin
        raise_error(qlt_pkg::ST_BACKSLASH);
      end
    end else if (c == qlt_pkg::CH_BSLASH) begin
      esc_pending = 1'b1;
    end else if (c == stop_a || c == stop_b) begin
      close_token();
    end else begin
      token_char(c);
    end
  endfunction

  function automatic void predict_item(logic kind, logic [qlt_pkg::CODE_W-1:0] c);
    int            n_before;
    qlt_pkg::res_t r;
    n_before = expected_q.size();
    if (kind == qlt_pkg::KIND_LINE_END) begin
      if (scan_mode == SCAN_SQUOTE) begin
        close_token();
      end else if (scan_mode == SCAN_DQUOTE || scan_mode == SCAN_BARE) begin
        if (esc_pending) raise_error(qlt_pkg::ST_BACKSLASH);
        else close_token();
      end
      add_event(qlt_pkg::EV_LINE_END, tok_cnt, '0, '0, line_st);
      reset_scan();
    end else if (!line_cut && line_len < qlt_pkg::MAX_LINE - 1) begin
      if (c == qlt_pkg::CH_NUL || c == qlt_pkg::CH_LF || c == qlt_pkg::CH_CR) begin
        line_cut = 1'b1;
      end else begin
        line_len++;
        case (scan_mode)
          SCAN_BETWEEN: begin
            if (c != qlt_pkg::CH_SPACE && c != qlt_pkg::CH_TAB) begin
              if (tok_cnt >= qlt_pkg::MAX_TOKENS) begin
                raise_error(qlt_pkg::ST_TOO_MANY);
              end else begin
                offset      = '0;
                esc_pending = 1'b0;
                if (c == qlt_pkg::CH_SEMI || c == qlt_pkg::CH_HASH) begin
                  scan_mode = SCAN_COMMENT;
                  add_event(qlt_pkg::EV_COMMENT_CHAR, tok_cnt, offset, c, qlt_pkg::ST_OK);
                  bump_offset();
                end else begin
                  tok_cnt++;
                  if (c == qlt_pkg::CH_SQUOTE) begin
                    scan_mode = SCAN_SQUOTE;
                  end else if (c == qlt_pkg::CH_DQUOTE) begin
                    scan_mode = SCAN_DQUOTE;
                  end else begin
                    scan_mode = SCAN_BARE;
                    escapable_char(c, qlt_pkg::CH_SPACE, qlt_pkg::CH_TAB);
                  end
                end
              end
            end
          end
          SCAN_SQUOTE: begin
            if (c == qlt_pkg::CH_SQUOTE) close_token();
            else token_char(c);
          end
          SCAN_DQUOTE:  escapable_char(c, qlt_pkg::CH_DQUOTE, qlt_pkg::CH_DQUOTE);
          SCAN_BARE:    escapable_char(c, qlt_pkg::CH_SPACE, qlt_pkg::CH_TAB);
          SCAN_COMMENT: begin
            add_event(qlt_pkg::EV_COMMENT_CHAR, tok_cnt, offset, c, qlt_pkg::ST_OK);
            bump_offset();
          end
          default: ;
        endcase
      end
    end
    // flag the final event of this item
    if (expected_q.size() > n_before) begin
      r      = expected_q.pop_back();
      r.last = 1'b1;
      expected_q.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    qlt_pkg::res_t want;
    if (!rst_ni) begin
      reset_scan();
      expected_q.delete();
    end else begin
      if (in_i.valid && in_i.ready) predict_item(in_i.kind, in_i.code);
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: event_res %0d token_index %0d position %0d",
                 res_i.event_res, res_i.token_index, res_i.position);
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          check_field("event_res",   32'(want.event_res),   32'(res_i.event_res));
          check_field("token_index", 32'(want.token_index), 32'(res_i.token_index));
          check_field("position",    32'(want.position),    32'(res_i.position));
          check_field("out_code",    32'(want.out_code),    32'(res_i.out_code));
          check_field("status",      32'(want.status),      32'(res_i.status));
          check_field("last",        32'(want.last),        32'(res_i.last));
        end
      end
    end
    fail_count_o <= fail_cnt;
    pending_o    <= expected_q.size();
  end

endmodule

// ===== tb/quoted_line_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// quoted_line_tokenizer_tb
// Feeds the tokenizer with lines of characters: a few hand-made lines for
// quotes, escapes, comments, dash stripping and errors, one overlong line,
// then random lines, mostly well-formed with random content. Four phases
// vary sender gaps and receiver stalls; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module quoted_line_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 310;

  logic clk;
  logic rst_n;

  qlt_in_if  in_if ();
  qlt_out_if out_if ();

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int items_sent;
  bit hold_tgl;

  logic [qlt_pkg::CODE_W-1:0] line_q[$];

  quoted_line_tokenizer uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  qlt_token_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_if),
    .res_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    bit hold_seen;
    int hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tgl != hold_seen) begin
        hold_seen = hold_tgl;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(input logic k, input logic [qlt_pkg::CODE_W-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= k;
    in_if.code  <= c;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(qlt_pkg::KIND_CHAR, line_q[i]);
    send_item(qlt_pkg::KIND_LINE_END, qlt_pkg::CODE_W'($urandom_range(16'hFFFF)));
  endtask

  // Hold the input until every queued event has come out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic void load_text(string s);
    line_q.delete();
    foreach (s[i]) line_q.push_back({8'h00, s[i]});
  endfunction

  function automatic logic [qlt_pkg::CODE_W-1:0] word_char();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return qlt_pkg::CODE_W'(16'h0061 + $urandom_range(25));
      5:             return qlt_pkg::CODE_W'(16'h0041 + $urandom_range(25));
      6:             return qlt_pkg::CODE_W'(16'h0030 + $urandom_range(9));
      7, 8:          return qlt_pkg::CODE_W'($urandom_range(16'hFFFF, 16'h0080));
      default:       return qlt_pkg::CH_DASH;
    endcase
  endfunction

  function automatic logic [qlt_pkg::CODE_W-1:0] any_char();
    case ($urandom_range(21))
      0:       return qlt_pkg::CH_SPACE;
      1:       return qlt_pkg::CH_TAB;
      2:       return qlt_pkg::CH_SQUOTE;
      3:       return qlt_pkg::CH_DQUOTE;
      4:       return qlt_pkg::CH_BSLASH;
      5:       return qlt_pkg::CH_SEMI;
      6:       return qlt_pkg::CH_HASH;
      7:       return qlt_pkg::CH_NUL;
      8:       return qlt_pkg::CH_LF;
      9:       return qlt_pkg::CH_CR;
      10:      return qlt_pkg::CODE_W'($urandom_range(16'h001F));
      default: return word_char();
    endcase
  endfunction

  function automatic void add_escape();
    line_q.push_back(qlt_pkg::CH_BSLASH);
    case ($urandom_range(2))
      0:       line_q.push_back(qlt_pkg::CH_DQUOTE);
      1:       line_q.push_back(qlt_pkg::CH_SPACE);
      default: line_q.push_back(qlt_pkg::CH_BSLASH);
    endcase
  endfunction

  function automatic void add_gap();
    repeat ($urandom_range(2, 1))
      line_q.push_back($urandom_range(1) ? qlt_pkg::CH_SPACE : qlt_pkg::CH_TAB);
  endfunction

  function automatic void add_bare(bit first);
    int n;
    n = $urandom_range(6, 1);
    if (first && $urandom_range(2) == 0)
      repeat ($urandom_range(2, 1)) line_q.push_back(qlt_pkg::CH_DASH);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(5) == 0) add_escape();
      else if (i > 0 && $urandom_range(9) == 0)
        line_q.push_back($urandom_range(1) ? qlt_pkg::CH_SQUOTE : qlt_pkg::CH_DQUOTE);
      else line_q.push_back(word_char());
    end
  endfunction

  function automatic void add_quoted(bit dq);
    logic [qlt_pkg::CODE_W-1:0] mark;
    mark = dq ? qlt_pkg::CH_DQUOTE : qlt_pkg::CH_SQUOTE;
    line_q.push_back(mark);
    repeat ($urandom_range(6)) begin
      if (dq && $urandom_range(5) == 0) begin
        add_escape();
      end else begin
        case ($urandom_range(7))
          0:       line_q.push_back(qlt_pkg::CH_SPACE);
          1:       line_q.push_back(qlt_pkg::CH_TAB);
          2:       line_q.push_back(dq ? qlt_pkg::CH_SQUOTE : qlt_pkg::CH_DQUOTE);
          3:       line_q.push_back(dq ? word_char() : qlt_pkg::CH_BSLASH);
          default: line_q.push_back(word_char());
        endcase
      end
    end
    // leave the quote open now and then
    if ($urandom_range(9) != 0) line_q.push_back(mark);
  endfunction

  function automatic void add_comment();
    line_q.push_back($urandom_range(1) ? qlt_pkg::CH_SEMI : qlt_pkg::CH_HASH);
    repeat ($urandom_range(8)) line_q.push_back(any_char());
  endfunction

  // Runs past the line length limit; later characters are dropped
  function automatic void add_long_line();
    for (int i = 0; i < 270; i++)
      line_q.push_back((i % 40 == 39) ? qlt_pkg::CH_SPACE
                                      : qlt_pkg::CODE_W'(16'h0061 + i % 26));
  endfunction

  function automatic void build_line();
    int shape;
    int ntok;
    int kind_sel;
    line_q.delete();
    shape = $urandom_range(99);
    if (shape < 8) begin
      repeat ($urandom_range(12)) line_q.push_back(any_char());
    end else if (shape == 8 && $urandom_range(1) == 0) begin
      add_long_line();
    end else begin
      ntok = (shape < 16) ? $urandom_range(19, 14) : $urandom_range(5);
      if ($urandom_range(3) == 0) add_gap();
      for (int t = 0; t < ntok; t++) begin
        kind_sel = $urandom_range(9);
        if (t == ntok - 1 && $urandom_range(6) == 0) add_comment();
        else if (kind_sel < 5) add_bare(t == 0);
        else add_quoted(kind_sel >= 7);
        // a closed quote ends its token, so the gap may be left out
        if (t != ntok - 1 && (kind_sel < 5 || $urandom_range(3) != 0)) add_gap();
      end
      if (ntok == 0 && $urandom_range(2) == 0) add_comment();
      if ($urandom_range(99) < 6) begin
        line_q.push_back(qlt_pkg::CH_BSLASH);
        if ($urandom_range(1)) line_q.push_back(word_char());
      end
      if ($urandom_range(99) < 4) begin
        case ($urandom_range(2))
          0:       line_q.push_back(qlt_pkg::CH_NUL);
          1:       line_q.push_back(qlt_pkg::CH_LF);
          default: line_q.push_back(qlt_pkg::CH_CR);
        endcase
        repeat ($urandom_range(4)) line_q.push_back(word_char());
      end
      if ($urandom_range(4) == 0) add_gap();
    end
  endfunction

  initial begin : stimulus
    int  phase_end;
    bit  held;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.kind   = qlt_pkg::KIND_CHAR;
    in_if.code   = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    items_sent   = 0;
    hold_tgl     = 1'b0;
    held         = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dash stripping, escaped space, closed single quote, open double quote
    load_text("--a\\ b 'c'\"e");
    send_line();
    // backslash right before the line end
    load_text("x\\");
    send_line();
    // comment with the top code, then a cut and an ignored character
    line_q.delete();
    line_q.push_back(qlt_pkg::CH_HASH);
    line_q.push_back(16'hFFFF);
    line_q.push_back(qlt_pkg::CH_NUL);
    line_q.push_back(16'h007A);
    send_line();
    // backslash before a plain letter
    load_text("\ty\\q");
    send_line();
    // empty line
    line_q.delete();
    send_line();
    line_q.delete();
    add_long_line();
    send_line();
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 85; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        // stall the output for a while and keep pushing so the input backs up
        if (p == 0 && !held && items_sent >= phase_end - 200) begin
          hold_tgl = ~hold_tgl;
          held     = 1'b1;
        end
        build_line();
        send_line();
        if ($urandom_range(24) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
